// ===== rtl/amd_pkg.sv =====
`default_nettype none

package amd_pkg;

    // field widths
    localparam int RAW_W      = 16;
    localparam int AXIS_W     = 12;
    localparam int DIFF_W     = 13;
    localparam int SQ_W       = 23;
    localparam int SUMSQ_W    = 24;
    localparam int FRAC_SHIFT = 8;
    localparam int ROOT_IN_W  = SUMSQ_W + FRAC_SHIFT;
    localparam int MAG_W      = 16;
    localparam int BSUM_W     = 24;
    localparam int SAMPLES_W  = 9;
    localparam int AXIS_SHIFT = 4;

    // default baseline window length
    localparam int BASELINE_SAMPLES_DEF = 16;

    // per-lane control from the sequencer
    typedef struct packed {
        logic load;
        logic square;
        logic prev_valid;
    } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/amd_lane.sv =====
`default_nettype none

module amd_lane (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire amd_pkg::lane_ctrl_t           ctrl,
    input  wire        [amd_pkg::RAW_W-1:0]    raw_word,
    output logic signed [amd_pkg::AXIS_W-1:0]  axis,
    output logic signed [amd_pkg::DIFF_W-1:0]  diff,
    output logic       [amd_pkg::AXIS_W-1:0]   abs_diff,
    output logic       [amd_pkg::SQ_W-1:0]     square
);

    logic signed [amd_pkg::AXIS_W-1:0]   axis_in;
    logic signed [amd_pkg::DIFF_W-1:0]   diff_in;
    logic signed [2*amd_pkg::AXIS_W-1:0] product;
    logic signed [amd_pkg::DIFF_W-1:0]   diff_neg;

    logic signed [amd_pkg::AXIS_W-1:0] axis_reg;
    logic signed [amd_pkg::AXIS_W-1:0] prev_reg;
    logic signed [amd_pkg::DIFF_W-1:0] diff_reg;
    logic        [amd_pkg::SQ_W-1:0]   square_reg;

    // arithmetic shift of the left-justified word is its upper bits
    assign axis_in = $signed(raw_word[amd_pkg::RAW_W-1:amd_pkg::AXIS_SHIFT]);

    // change against the previous sample, zero on the first one
    always_comb
    begin
        if (ctrl.prev_valid)
        begin
            diff_in = {axis_in[amd_pkg::AXIS_W-1], axis_in}
                    - {prev_reg[amd_pkg::AXIS_W-1], prev_reg};
        end
        else
        begin
            diff_in = '0;
        end
    end

    assign product  = axis_reg * axis_reg;
    assign diff_neg = -diff_reg;

    // magnitude of the change always fits in the axis width
    assign abs_diff = diff_reg[amd_pkg::DIFF_W-1] ? diff_neg[amd_pkg::AXIS_W-1:0]
                                                  : diff_reg[amd_pkg::AXIS_W-1:0];

    // capture on transaction, square when the square control is set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg   <= '0;
            prev_reg   <= '0;
            diff_reg   <= '0;
            square_reg <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                axis_reg <= axis_in;
                prev_reg <= axis_in;
                diff_reg <= diff_in;
            end
            if (ctrl.square)
            begin
                square_reg <= product[amd_pkg::SQ_W-1:0];
            end
        end
    end

    assign axis   = axis_reg;
    assign diff   = diff_reg;
    assign square = square_reg;

endmodule

`default_nettype wire

// ===== rtl/amd_merge.sv =====
`default_nettype none

module amd_merge (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              en,
    input  wire  [amd_pkg::SQ_W-1:0]         sq_x,
    input  wire  [amd_pkg::SQ_W-1:0]         sq_y,
    input  wire  [amd_pkg::SQ_W-1:0]         sq_z,
    input  wire  [amd_pkg::AXIS_W-1:0]       abs_x,
    input  wire  [amd_pkg::AXIS_W-1:0]       abs_y,
    input  wire  [amd_pkg::AXIS_W-1:0]       abs_z,
    output logic [amd_pkg::SUMSQ_W-1:0]      sum_sq,
    output logic [amd_pkg::AXIS_W-1:0]       largest
);

    logic [amd_pkg::SUMSQ_W-1:0] sum_next;
    logic [amd_pkg::AXIS_W-1:0]  max_xy;
    logic [amd_pkg::AXIS_W-1:0]  largest_next;
    logic [amd_pkg::SUMSQ_W-1:0] sum_reg;
    logic [amd_pkg::AXIS_W-1:0]  largest_reg;

    // sum of squares cannot exceed three times the largest square
    assign sum_next = amd_pkg::SUMSQ_W'(sq_x) + amd_pkg::SUMSQ_W'(sq_y)
                    + amd_pkg::SUMSQ_W'(sq_z);

    // largest per-axis change
    assign max_xy       = (abs_x >= abs_y) ? abs_x : abs_y;
    assign largest_next = (max_xy >= abs_z) ? max_xy : abs_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            largest_reg <= '0;
        end
        else if (en)
        begin
            sum_reg     <= sum_next;
            largest_reg <= largest_next;
        end
    end

    assign sum_sq  = sum_reg;
    assign largest = largest_reg;

endmodule

`default_nettype wire

// ===== rtl/amd_isqrt.sv =====
`default_nettype none

module amd_isqrt (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    input  wire  [amd_pkg::ROOT_IN_W-1:0]     operand,
    output logic                              done,
    output logic [amd_pkg::MAG_W-1:0]         root
);

    localparam int CNT_W = $clog2(amd_pkg::MAG_W);
    localparam int REM_W = amd_pkg::MAG_W + 3;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(amd_pkg::MAG_W - 1);

    logic [amd_pkg::ROOT_IN_W-1:0] op_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [amd_pkg::MAG_W-1:0]     root_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;

    // one result bit per cycle: bring down two operand bits, try root*4+1
    assign rem_shift = {rem_reg[REM_W-3:0],
                        op_reg[amd_pkg::ROOT_IN_W-1:amd_pkg::ROOT_IN_W-2]};
    assign trial     = REM_W'({root_reg, 2'b01});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == LAST);
            if (start)
            begin
                op_reg   <= operand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                op_reg <= {op_reg[amd_pkg::ROOT_IN_W-3:0], 2'b00};
                if (rem_shift >= trial)
                begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[amd_pkg::MAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[amd_pkg::MAG_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== rtl/amd_div.sv =====
`default_nettype none

module amd_div #(
    parameter int DIVISOR = amd_pkg::BASELINE_SAMPLES_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire  [amd_pkg::BSUM_W-1:0]       dividend,
    output logic                             done,
    output logic [amd_pkg::MAG_W-1:0]        quotient
);

    // floor(x / d) equals (x * ceil(2^32 / d)) >> 32 for any 24-bit x and d up to 256
    localparam int RECIP_SHIFT = 32;
    localparam int HALF_W      = 16;
    localparam int HI_W        = amd_pkg::BSUM_W + RECIP_SHIFT + 1 - HALF_W;
    localparam int LO_W        = amd_pkg::BSUM_W + HALF_W;
    localparam int PROD_W      = amd_pkg::BSUM_W + RECIP_SHIFT + 1;
    localparam logic [RECIP_SHIFT:0] RECIP = (RECIP_SHIFT + 1)'(
        ((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    localparam logic [RECIP_SHIFT-HALF_W:0] RECIP_HI = RECIP[RECIP_SHIFT:HALF_W];
    localparam logic [HALF_W-1:0]           RECIP_LO = RECIP[HALF_W-1:0];

    logic [HI_W-1:0]           hi_reg;
    logic [LO_W-1:0]           lo_reg;
    logic [amd_pkg::MAG_W-1:0] quot_reg;
    logic                      pend_reg;
    logic                      done_reg;

    logic [PROD_W-1:0] prod_sum;

    // reciprocal split in two halves: partial products, then one add
    assign prod_sum = {hi_reg, HALF_W'(0)} + PROD_W'(lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg   <= '0;
            lo_reg   <= '0;
            quot_reg <= '0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= start;
            done_reg <= pend_reg;
            if (start)
            begin
                hi_reg <= HI_W'(dividend) * HI_W'(RECIP_HI);
                lo_reg <= LO_W'(dividend) * LO_W'(RECIP_LO);
            end
            if (pend_reg)
            begin
                quot_reg <= prod_sum[RECIP_SHIFT+amd_pkg::MAG_W-1:RECIP_SHIFT];
            end
        end
    end

    // the average never exceeds the largest magnitude
    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/accel_motion_deviation.sv =====
`default_nettype none

// Motion detector for a three-axis accelerometer. Each input transaction carries
// three left-justified 16-bit words; the result transaction gives the signed
// 12-bit axes, the per-axis change from the previous sample (zero on the first),
// the largest absolute change, and the deviation of the Q12.4 vector magnitude
// from a baseline taken as the average of the first BASELINE_SAMPLES magnitudes
// (zero, with baseline_ready low, until that window is complete). Three axis
// lanes work side by side and a merge stage sums their squares and picks the
// largest change. A new transaction is accepted only after the previous one
// has passed the 16-step bit-serial square root and, once the output register
// is free, entered it; the sample that completes the baseline also passes the
// two-stage reciprocal multiply that forms the average. A finished result
// waits in the output register while the next transaction is accepted.
module accel_motion_deviation #(
    parameter int BASELINE_SAMPLES = amd_pkg::BASELINE_SAMPLES_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire         [amd_pkg::RAW_W-1:0]    raw_word_x,
    input  wire         [amd_pkg::RAW_W-1:0]    raw_word_y,
    input  wire         [amd_pkg::RAW_W-1:0]    raw_word_z,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic signed [amd_pkg::AXIS_W-1:0]   accel_x,
    output logic signed [amd_pkg::AXIS_W-1:0]   accel_y,
    output logic signed [amd_pkg::AXIS_W-1:0]   accel_z,
    output logic signed [amd_pkg::DIFF_W-1:0]   change_x,
    output logic signed [amd_pkg::DIFF_W-1:0]   change_y,
    output logic signed [amd_pkg::DIFF_W-1:0]   change_z,
    output logic        [amd_pkg::AXIS_W-1:0]   largest_change,
    output logic        [amd_pkg::MAG_W-1:0]    deviation,
    output logic                                baseline_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_MERGE,
        S_ROOT_GO,
        S_ROOT,
        S_DIV_GO,
        S_DIV,
        S_OUT
    } state_t;

    localparam logic [amd_pkg::SAMPLES_W-1:0] WINDOW =
        amd_pkg::SAMPLES_W'(BASELINE_SAMPLES);

    // lane outputs
    amd_pkg::lane_ctrl_t               lane_ctrl;
    logic signed [amd_pkg::AXIS_W-1:0] axis_x, axis_y, axis_z;
    logic signed [amd_pkg::DIFF_W-1:0] diff_x, diff_y, diff_z;
    logic        [amd_pkg::AXIS_W-1:0] abs_x, abs_y, abs_z;
    logic        [amd_pkg::SQ_W-1:0]   sq_x, sq_y, sq_z;

    // merge, root and divide
    logic                          merge_en;
    logic [amd_pkg::SUMSQ_W-1:0]   sum_sq;
    logic [amd_pkg::AXIS_W-1:0]    largest;
    logic                          root_start;
    logic                          root_done;
    logic [amd_pkg::MAG_W-1:0]     root;
    logic                          div_start;
    logic                          div_done;
    logic [amd_pkg::MAG_W-1:0]     quotient;
    logic                          in_xfer;
    logic                          out_free;
    logic [amd_pkg::MAG_W-1:0]     dev_calc;

    // sequencer state and registered outputs
    state_t                            state_reg, state_next;
    logic                              prev_valid_reg, prev_valid_next;
    logic [amd_pkg::SAMPLES_W-1:0]     remaining_reg, remaining_next;
    logic [amd_pkg::BSUM_W-1:0]        bsum_reg, bsum_next;
    logic [amd_pkg::MAG_W-1:0]         average_reg, average_next;
    logic [amd_pkg::MAG_W-1:0]         mag_reg, mag_next;
    logic                              out_valid_reg, out_valid_next;
    logic signed [amd_pkg::AXIS_W-1:0] accel_x_reg, accel_x_next;
    logic signed [amd_pkg::AXIS_W-1:0] accel_y_reg, accel_y_next;
    logic signed [amd_pkg::AXIS_W-1:0] accel_z_reg, accel_z_next;
    logic signed [amd_pkg::DIFF_W-1:0] change_x_reg, change_x_next;
    logic signed [amd_pkg::DIFF_W-1:0] change_y_reg, change_y_next;
    logic signed [amd_pkg::DIFF_W-1:0] change_z_reg, change_z_next;
    logic        [amd_pkg::AXIS_W-1:0] largest_reg, largest_next;
    logic        [amd_pkg::MAG_W-1:0]  deviation_reg, deviation_next;
    logic                              ready_reg, ready_next;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign lane_ctrl.load       = in_xfer;
    assign lane_ctrl.square     = (state_reg == S_SQUARE);
    assign lane_ctrl.prev_valid = prev_valid_reg;
    assign merge_en             = (state_reg == S_MERGE);
    assign root_start           = (state_reg == S_ROOT_GO);
    assign div_start            = (state_reg == S_DIV_GO);

    // axis lanes
    amd_lane u_lane_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .raw_word (raw_word_x),
        .axis     (axis_x),
        .diff     (diff_x),
        .abs_diff (abs_x),
        .square   (sq_x)
    );

    amd_lane u_lane_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .raw_word (raw_word_y),
        .axis     (axis_y),
        .diff     (diff_y),
        .abs_diff (abs_y),
        .square   (sq_y)
    );

    amd_lane u_lane_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .raw_word (raw_word_z),
        .axis     (axis_z),
        .diff     (diff_z),
        .abs_diff (abs_z),
        .square   (sq_z)
    );

    // combine lanes
    amd_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (merge_en),
        .sq_x    (sq_x),
        .sq_y    (sq_y),
        .sq_z    (sq_z),
        .abs_x   (abs_x),
        .abs_y   (abs_y),
        .abs_z   (abs_z),
        .sum_sq  (sum_sq),
        .largest (largest)
    );

    // magnitude in Q12.4
    amd_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (root_start),
        .operand ({sum_sq, amd_pkg::FRAC_SHIFT'(0)}),
        .done    (root_done),
        .root    (root)
    );

    // baseline average
    amd_div #(
        .DIVISOR (BASELINE_SAMPLES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (bsum_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign dev_calc = (mag_reg >= average_reg) ? mag_reg - average_reg
                                               : average_reg - mag_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        prev_valid_next = prev_valid_reg;
        remaining_next  = remaining_reg;
        bsum_next       = bsum_reg;
        average_next    = average_reg;
        mag_next        = mag_reg;
        out_valid_next  = out_valid_reg;
        accel_x_next    = accel_x_reg;
        accel_y_next    = accel_y_reg;
        accel_z_next    = accel_z_reg;
        change_x_next   = change_x_reg;
        change_y_next   = change_y_reg;
        change_z_next   = change_z_reg;
        largest_next    = largest_reg;
        deviation_next  = deviation_reg;
        ready_next      = ready_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    prev_valid_next = 1'b1;
                    state_next      = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                state_next = S_ROOT_GO;
            end
            S_ROOT_GO:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    mag_next   = root;
                    state_next = S_OUT;
                    if (remaining_reg != '0)
                    begin
                        bsum_next      = bsum_reg + amd_pkg::BSUM_W'(root);
                        remaining_next = remaining_reg - amd_pkg::SAMPLES_W'(1);
                        if (remaining_reg == amd_pkg::SAMPLES_W'(1))
                        begin
                            state_next = S_DIV_GO;
                        end
                    end
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    average_next = quotient;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    accel_x_next   = axis_x;
                    accel_y_next   = axis_y;
                    accel_z_next   = axis_z;
                    change_x_next  = diff_x;
                    change_y_next  = diff_y;
                    change_z_next  = diff_z;
                    largest_next   = largest;
                    if (remaining_reg == '0)
                    begin
                        deviation_next = dev_calc;
                        ready_next     = 1'b1;
                    end
                    else
                    begin
                        deviation_next = '0;
                        ready_next     = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prev_valid_reg <= 1'b0;
            remaining_reg  <= WINDOW;
            bsum_reg       <= '0;
            average_reg    <= '0;
            mag_reg        <= '0;
            out_valid_reg  <= 1'b0;
            accel_x_reg    <= '0;
            accel_y_reg    <= '0;
            accel_z_reg    <= '0;
            change_x_reg   <= '0;
            change_y_reg   <= '0;
            change_z_reg   <= '0;
            largest_reg    <= '0;
            deviation_reg  <= '0;
            ready_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_valid_reg <= prev_valid_next;
            remaining_reg  <= remaining_next;
            bsum_reg       <= bsum_next;
            average_reg    <= average_next;
            mag_reg        <= mag_next;
            out_valid_reg  <= out_valid_next;
            accel_x_reg    <= accel_x_next;
            accel_y_reg    <= accel_y_next;
            accel_z_reg    <= accel_z_next;
            change_x_reg   <= change_x_next;
            change_y_reg   <= change_y_next;
            change_z_reg   <= change_z_next;
            largest_reg    <= largest_next;
            deviation_reg  <= deviation_next;
            ready_reg      <= ready_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accel_x        = accel_x_reg;
    assign accel_y        = accel_y_reg;
    assign accel_z        = accel_z_reg;
    assign change_x       = change_x_reg;
    assign change_y       = change_y_reg;
    assign change_z       = change_z_reg;
    assign largest_change = largest_reg;
    assign deviation      = deviation_reg;
    assign baseline_ready = ready_reg;

endmodule

`default_nettype wire

// ===== tb/sv/accel_motion_deviation_tb.sv =====
module accel_motion_deviation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW       = amd_pkg::BASELINE_SAMPLES_DEF;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_WAIT  = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 200;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 130;

    // one expected result transaction
    typedef struct {
        logic signed [amd_pkg::AXIS_W-1:0] axis_x;
        logic signed [amd_pkg::AXIS_W-1:0] axis_y;
        logic signed [amd_pkg::AXIS_W-1:0] axis_z;
        logic signed [amd_pkg::DIFF_W-1:0] delta_x;
        logic signed [amd_pkg::DIFF_W-1:0] delta_y;
        logic signed [amd_pkg::DIFF_W-1:0] delta_z;
        logic        [amd_pkg::AXIS_W-1:0] peak_delta;
        logic        [amd_pkg::MAG_W-1:0]  offset;
        logic                              settled;
    } motion_result_t;

    // motion predictor and store of pending results
    class motion_scoreboard;
        logic signed [amd_pkg::AXIS_W-1:0] last_axis [3];
        bit                                have_last;
        int                                window_left;
        longint                            baseline_total;
        int                                baseline_mean;
        motion_result_t                    expected_q[$];
        int                                errors;

        function new();
            last_axis      = '{default: '0};
            have_last      = 1'b0;
            window_left    = WINDOW;
            baseline_total = 0;
            baseline_mean  = 0;
            errors         = 0;
        endfunction

        // floor of the square root, 16 result bits
        function int unsigned floor_root(longint unsigned energy);
            int unsigned root;
            int unsigned trial;
            root = 0;
            for (int b = 15; b >= 0; b--)
            begin
                trial = root | (32'd1 << b);
                if (longint'(trial) * longint'(trial) <= energy)
                    root = trial;
            end
            return root;
        endfunction

        // predict the result of one accepted sample
        function void note_sample(logic [15:0] wx, logic [15:0] wy, logic [15:0] wz);
            logic [15:0]                       words [3];
            logic signed [amd_pkg::AXIS_W-1:0] axis [3];
            logic signed [amd_pkg::DIFF_W-1:0] delta [3];
            longint unsigned                   energy;
            int                                step;
            int                                peak;
            int                                mag;
            motion_result_t                    r;
            words  = '{wx, wy, wz};
            energy = 0;
            peak   = 0;
            for (int i = 0; i < 3; i++)
            begin
                // left-justified word, arithmetic shift by four
                axis[i] = words[i][15:amd_pkg::AXIS_SHIFT];
                if (have_last)
                    delta[i] = amd_pkg::DIFF_W'(axis[i]) - amd_pkg::DIFF_W'(last_axis[i]);
                else
                    delta[i] = '0;
                step     = (delta[i] < 0) ? -int'(delta[i]) : int'(delta[i]);
                if (step > peak)
                    peak = step;
                energy += longint'(axis[i]) * longint'(axis[i]);
            end
            last_axis = axis;
            have_last = 1'b1;
            mag = int'(floor_root(energy << 8));

            // baseline window, average taken on the closing sample
            if (window_left != 0)
            begin
                baseline_total += mag;
                window_left--;
                if (window_left == 0)
                    baseline_mean = int'(baseline_total / WINDOW);
            end

            r.axis_x     = axis[0];
            r.axis_y     = axis[1];
            r.axis_z     = axis[2];
            r.delta_x    = delta[0];
            r.delta_y    = delta[1];
            r.delta_z    = delta[2];
            r.peak_delta = peak[amd_pkg::AXIS_W-1:0];
            r.settled    = (window_left == 0);
            r.offset     = '0;
            if (window_left == 0)
                r.offset = (mag >= baseline_mean) ? 16'(mag - baseline_mean)
                                                  : 16'(baseline_mean - mag);
            expected_q.push_back(r);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void compare_field(string field, logic signed [16:0] want,
                                    logic signed [16:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0d ns: %s mismatch, expected %0d, actual %0d",
                             $time, field, want, got);
            end
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(logic signed [amd_pkg::AXIS_W-1:0] ax,
                                   logic signed [amd_pkg::AXIS_W-1:0] ay,
                                   logic signed [amd_pkg::AXIS_W-1:0] az,
                                   logic signed [amd_pkg::DIFF_W-1:0] cx,
                                   logic signed [amd_pkg::DIFF_W-1:0] cy,
                                   logic signed [amd_pkg::DIFF_W-1:0] cz,
                                   logic [amd_pkg::AXIS_W-1:0] lc,
                                   logic [amd_pkg::MAG_W-1:0] dv,
                                   logic rdy);
            motion_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0d ns: unexpected result, expected none, actual accel %0d %0d %0d",
                             $time, ax, ay, az);
                return;
            end
            want = expected_q.pop_front();
            compare_field("accel_x", want.axis_x, ax);
            compare_field("accel_y", want.axis_y, ay);
            compare_field("accel_z", want.axis_z, az);
            compare_field("change_x", want.delta_x, cx);
            compare_field("change_y", want.delta_y, cy);
            compare_field("change_z", want.delta_z, cz);
            compare_field("largest_change", want.peak_delta, lc);
            compare_field("deviation", want.offset, dv);
            compare_field("baseline_ready", want.settled, rdy);
        endfunction
    endclass

    logic                              clk        = 1'b0;
    logic                              rst_n      = 1'b0;
    logic                              in_valid   = 1'b0;
    logic                              in_ready;
    logic [amd_pkg::RAW_W-1:0]         raw_word_x = '0;
    logic [amd_pkg::RAW_W-1:0]         raw_word_y = '0;
    logic [amd_pkg::RAW_W-1:0]         raw_word_z = '0;
    logic                              out_valid;
    logic                              out_ready  = 1'b0;
    logic signed [amd_pkg::AXIS_W-1:0] accel_x;
    logic signed [amd_pkg::AXIS_W-1:0] accel_y;
    logic signed [amd_pkg::AXIS_W-1:0] accel_z;
    logic signed [amd_pkg::DIFF_W-1:0] change_x;
    logic signed [amd_pkg::DIFF_W-1:0] change_y;
    logic signed [amd_pkg::DIFF_W-1:0] change_z;
    logic [amd_pkg::AXIS_W-1:0]        largest_change;
    logic [amd_pkg::MAG_W-1:0]         deviation;
    logic                              baseline_ready;

    motion_scoreboard sb = new();

    bit          tx_idle      = 1'b0;
    bit          rx_idle      = 1'b0;
    bit          hold_request = 1'b0;
    int          cycle_count  = 0;
    logic [15:0] pose_x       = 16'h1000;
    logic [15:0] pose_y       = 16'hF000;
    logic [15:0] pose_z       = 16'h4000;

    accel_motion_deviation #(
        .BASELINE_SAMPLES(WINDOW)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_word_x     (raw_word_x),
        .raw_word_y     (raw_word_y),
        .raw_word_z     (raw_word_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .change_x       (change_x),
        .change_y       (change_y),
        .change_z       (change_z),
        .largest_change (largest_change),
        .deviation      (deviation),
        .baseline_ready (baseline_ready)
    );

    // 4 ns clock
    always #2 clk = ~clk;

    // watch both channels for completed transactions
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_sample(raw_word_x, raw_word_y, raw_word_z);
        if (rst_n && out_valid && out_ready)
            sb.check_result(accel_x, accel_y, accel_z, change_x, change_y, change_z,
                            largest_change, deviation, baseline_ready);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, one long hold on request
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            stall = rx_idle ? int'($urandom_range(0, 5)) : 0;
            if (hold_request)
            begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // offer one sample and wait for its transaction
    task automatic send_sample(input logic [15:0] wx, input logic [15:0] wy,
                               input logic [15:0] wz);
        int gap;
        gap = tx_idle ? int'($urandom_range(0, 5)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        raw_word_x <= wx;
        raw_word_y <= wy;
        raw_word_z <= wz;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop offering until every predicted result has come back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [15:0] jitter(input logic [15:0] centre, input int spread);
        return centre + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
    endfunction

    function automatic logic [15:0] corner_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'h7FF0;
            default: return 16'h800F;
        endcase
    endfunction

    // mostly a sensor at rest with jitter, plus noise and corner words
    task automatic random_sample();
        int unsigned kind;
        logic [15:0] wx;
        logic [15:0] wy;
        logic [15:0] wz;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                pose_x = 16'($urandom);
                pose_y = 16'($urandom);
                pose_z = 16'($urandom);
            end
            wx = jitter(pose_x, 256);
            wy = jitter(pose_y, 256);
            wz = jitter(pose_z, 256);
        end
        else if (kind <= 7)
        begin
            wx = 16'($urandom);
            wy = 16'($urandom);
            wz = 16'($urandom);
        end
        else if (kind == 8)
        begin
            wx = corner_word();
            wy = corner_word();
            wz = corner_word();
        end
        else
        begin
            wx = jitter(16'h0000, 64);
            wy = jitter(16'h0000, 64);
            wz = jitter(16'h0000, 64);
        end
        send_sample(wx, wy, wz);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // baseline window: first sample, axis extremes, full-scale changes
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7FF0, 16'h7FF0, 16'h7FF0);
        send_sample(16'hFFFF, 16'h0000, 16'h000F);
        send_sample(16'h0010, 16'hFFF0, 16'h8000);
        send_sample(16'h8000, 16'h7FF0, 16'h0000);
        send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
        send_sample(16'h5555, 16'hAAAA, 16'h5555);
        send_sample(16'h0000, 16'h8000, 16'h7FF0);
        send_sample(16'h7FF0, 16'h0000, 16'h8000);
        send_sample(16'hFFF0, 16'h0010, 16'hFFFF);
        send_sample(16'h1000, 16'hF000, 16'h4000);
        send_sample(16'h1008, 16'hF004, 16'h400C);
        send_sample(16'h0F00, 16'hF100, 16'h3FF0);
        // closes the window and is compared with the new average
        send_sample(16'h1000, 16'hF000, 16'h4000);

        // after the baseline: largest and zero magnitude, no change
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h1000, 16'hF000, 16'h4000);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);

        // random phases with changing stall patterns
        for (int phase = 0; phase < PHASES; phase++)
        begin
            tx_idle = (phase % 4 == 0) || (phase % 4 == 2);
            rx_idle = (phase % 4 == 0) || (phase % 4 == 3);
            if (phase == 2)
            begin
                // back-pressure: receiver holds while samples keep coming
                tx_idle      = 1'b0;
                hold_request = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                random_sample();
            if (phase == 5)
                wait_all_results();
        end

        wait_all_results();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/amd_pkg.sv
rtl/amd_lane.sv
rtl/amd_merge.sv
rtl/amd_isqrt.sv
rtl/amd_div.sv
rtl/accel_motion_deviation.sv
tb/sv/accel_motion_deviation_tb.sv
